### design/lr_pkg.sv
package lr_pkg;

  localparam int COORD_W   = 6;
  localparam int SIZE_W    = 7;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DVD_W     = 12;
  localparam int CNT_W     = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE   = 2'd2;

  // divider pass lengths
  localparam logic [CNT_W-1:0] DIV_MINOR_BITS = 4'd12;
  localparam logic [CNT_W-1:0] DIV_MOD_BITS   = 4'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_POINT,
    ST_DIV,
    ST_MINOR,
    ST_FIXUP,
    ST_MODX,
    ST_MODY,
    ST_EMIT
  } lr_state_t;

endpackage

### design/line_rasterizer.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | in_valid / in_stall    | start_x, start_y, end_x, end_y, line_color
// out      | output    | out_valid / out_stall  | pixel_x, pixel_y, pixel_color,
//          |           |                        | write_enable, last_point
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One line takes a setup state, then per point: a state for the major coordinate, a pass
// through the shared restoring divider and a clamp state when the minor delta is nonzero,
// a fixup state, the x and y modulo divider passes in wrap mode, and an output state
// that holds while out_stall is high.
// Reset (rst, synchronous) returns to idle and loads the grid registers with 64/64/clip.
// in_stall is high from acceptance until the last point leaves; out_stall holds the point.
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   start_x,
  input  logic [COORD_W-1:0]   start_y,
  input  logic [COORD_W-1:0]   end_x,
  input  logic [COORD_W-1:0]   end_y,
  input  logic [COLOR_W-1:0]   line_color,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   pixel_x,
  output logic [COORD_W-1:0]   pixel_y,
  output logic [COLOR_W-1:0]   pixel_color,
  output logic                 write_enable,
  output logic                 last_point,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam logic [SIZE_W-1:0] GridMax = SIZE_W'(GRID_SIZE);

  lr_state_t state, state_next;

  logic [SIZE_W-1:0]  grid_width, grid_height;
  logic               wrap_mode;
  logic [SIZE_W-1:0]  w_eff, h_eff;

  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COLOR_W-1:0] color;
  logic               x_major, maj_neg, m_neg;
  logic [SIZE_W-1:0]  m_abs;
  logic [COORD_W-1:0] steps, k;
  logic [DVD_W-1:0]   prod;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic               we;

  // shared divider
  logic [DVD_W-1:0]   dvd, dvd_n;
  logic [COORD_W-1:0] rem, rem_n;
  logic [CNT_W-1:0]   cnt;
  logic [SIZE_W-1:0]  divisor, trial, diff;
  logic               ge;

  // setup terms
  logic [COORD_W:0]   xd, yd;
  logic [COORD_W-1:0] xa, ya, minor_abs;
  logic               x_major_c;

  // per-point terms
  logic [COORD_W-1:0] maj_start, major_c, min_start, min_end, minor_c;
  logic [SIZE_W-1:0]  q;
  logic [SIZE_W:0]    t_pos;
  logic signed [SIZE_W+1:0] t_neg;
  logic               last_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      wrap_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_WRAP_MODE:   wrap_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign w_eff = (grid_width == '0) ? SIZE_W'(1) :
                 (grid_width > GridMax) ? GridMax : grid_width;
  assign h_eff = (grid_height == '0) ? SIZE_W'(1) :
                 (grid_height > GridMax) ? GridMax : grid_height;

  assign xd        = {1'b0, ex} - {1'b0, sx};
  assign yd        = {1'b0, ey} - {1'b0, sy};
  assign xa        = xd[COORD_W] ? COORD_W'(-xd) : xd[COORD_W-1:0];
  assign ya        = yd[COORD_W] ? COORD_W'(-yd) : yd[COORD_W-1:0];
  assign x_major_c = xa > ya;
  assign minor_abs = x_major_c ? ya : xa;

  always_comb begin
    case (state)
      ST_MODX: divisor = w_eff;
      ST_MODY: divisor = h_eff;
      default: divisor = {1'b0, steps};
    endcase
  end

  // one quotient bit per cycle
  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= divisor;
  assign diff  = trial - divisor;
  assign rem_n = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
  assign dvd_n = {dvd[DVD_W-2:0], ge};

  assign maj_start = x_major ? sx : sy;
  assign major_c   = maj_neg ? maj_start - k : maj_start + k;
  assign min_start = x_major ? sy : sx;
  assign min_end   = x_major ? ey : ex;
  assign q         = dvd[SIZE_W-1:0];
  assign t_pos     = {2'b00, min_start} + {1'b0, q};
  assign t_neg     = $signed({3'b000, min_start}) - $signed({2'b00, q});

  // clamp so the minor coordinate never passes the end point
  always_comb begin
    if (!m_neg) begin
      minor_c = (t_pos > {2'b00, min_end}) ? min_end : t_pos[COORD_W-1:0];
    end else begin
      minor_c = (t_neg < $signed({3'b000, min_end})) ? min_end : t_neg[COORD_W-1:0];
    end
  end

  assign last_c = k == steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_POINT;
      ST_POINT: state_next = (m_abs == '0) ? ST_FIXUP : ST_DIV;
      ST_DIV:   if (cnt == CNT_W'(1)) state_next = ST_MINOR;
      ST_MINOR: state_next = ST_FIXUP;
      ST_FIXUP: state_next = wrap_mode ? ST_MODX : ST_EMIT;
      ST_MODX:  if (cnt == CNT_W'(1)) state_next = ST_MODY;
      ST_MODY:  if (cnt == CNT_W'(1)) state_next = ST_EMIT;
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = last_c ? ST_IDLE : ST_POINT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sx    <= start_x;
          sy    <= start_y;
          ex    <= end_x;
          ey    <= end_y;
          color <= line_color;
        end
      end
      ST_SETUP: begin
        x_major <= x_major_c;
        steps   <= x_major_c ? xa : ya;
        maj_neg <= x_major_c ? xd[COORD_W] : yd[COORD_W];
        m_neg   <= x_major_c ? yd[COORD_W] : xd[COORD_W];
        m_abs   <= (minor_abs == '0) ? '0 : {1'b0, minor_abs} + SIZE_W'(1);
        k       <= '0;
        prod    <= '0;
      end
      ST_POINT: begin
        if (x_major) cur_x <= major_c;
        else         cur_y <= major_c;
        if (m_abs == '0) begin
          if (x_major) cur_y <= sy;
          else         cur_x <= sx;
        end
        dvd <= prod;
        rem <= '0;
        cnt <= DIV_MINOR_BITS;
      end
      ST_DIV: begin
        dvd <= dvd_n;
        rem <= rem_n;
        cnt <= cnt - CNT_W'(1);
      end
      ST_MINOR: begin
        if (x_major) cur_y <= minor_c;
        else         cur_x <= minor_c;
      end
      ST_FIXUP: begin
        dvd <= {cur_x, {(DVD_W-COORD_W){1'b0}}};
        rem <= '0;
        cnt <= DIV_MOD_BITS;
        we  <= !(({1'b0, cur_x} >= w_eff) || ({1'b0, cur_y} >= h_eff));
      end
      ST_MODX: begin
        if (cnt == CNT_W'(1)) begin
          cur_x <= rem_n;
          dvd   <= {cur_y, {(DVD_W-COORD_W){1'b0}}};
          rem   <= '0;
          cnt   <= DIV_MOD_BITS;
        end else begin
          dvd <= dvd_n;
          rem <= rem_n;
          cnt <= cnt - CNT_W'(1);
        end
      end
      ST_MODY: begin
        dvd <= dvd_n;
        rem <= rem_n;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          cur_y <= rem_n;
          we    <= 1'b1;
        end
      end
      ST_EMIT: begin
        // advance to the next point along the major axis
        if (!out_stall && !last_c) begin
          k    <= k + COORD_W'(1);
          prod <= prod + DVD_W'(m_abs);
        end
      end
      default: ;
    endcase
  end

  assign pixel_x      = cur_x;
  assign pixel_y      = cur_y;
  assign pixel_color  = color;
  assign write_enable = we;
  assign last_point   = last_c;

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a point is pending");

  a_clip_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> !wrap_mode)
    else $error("point clipped in wrap mode");

  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wrap_mode) |->
      (({1'b0, pixel_x} < w_eff) && ({1'b0, pixel_y} < h_eff)))
    else $error("wrapped point outside grid");

endmodule
